// File: rtl/core/clock_divider_factor_search_unit_macros.svh
// assertion helpers shared by the block
`ifndef CLOCK_DIVIDER_FACTOR_SEARCH_UNIT_MACROS_SVH
`define CLOCK_DIVIDER_FACTOR_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define CDFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, held off during reset
`define CDFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// File: rtl/core/cdfs_pkg.sv
`default_nettype none
package cdfs_pkg;

    localparam int unsigned DIV_W = 32;

    localparam logic [31:0] LOW_REQUEST_LIMIT = 32'd4000000;
    localparam logic [20:0] HZ_PER_MHZ        = 21'd1000000;
    localparam logic [20:0] HZ_PER_MHZ_X2     = 21'd2000000;

    localparam int unsigned CTRL_ENABLE_BIT = 31;
    localparam int unsigned CTRL_SOURCE_BIT = 24;

    // configuration register indexes
    localparam logic [1:0] CFG_CRYSTAL_MHZ   = 2'd0;
    localparam logic [1:0] CFG_PLL_MHZ       = 2'd1;
    localparam logic [1:0] CFG_PREFER_PARENT = 2'd2;
    localparam logic [1:0] CFG_PARENT_HZ     = 2'd3;

    localparam logic [6:0]  CRYSTAL_MHZ_RST   = 7'd24;
    localparam logic [10:0] PLL_MHZ_RST       = 11'd600;
    localparam logic        PREFER_PARENT_RST = 1'b0;
    localparam logic [31:0] PARENT_HZ_RST     = 32'd0;

    typedef struct packed {
        logic done;
        logic rem_nz;
    } t_div_stat;

    typedef struct packed {
        logic done;
        logic found;
    } t_search_stat;

endpackage
`default_nettype wire

// File: rtl/core/cdfs_divider.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module cdfs_divider (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [cdfs_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [cdfs_pkg::DIV_W-1:0]   i_divisor,
    output cdfs_pkg::t_div_stat               o_stat,
    output logic      [cdfs_pkg::DIV_W-1:0]   o_quot
);

    localparam int unsigned W  = cdfs_pkg::DIV_W;
    localparam int unsigned CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_dvsr;

    logic [W:0]    trial;
    logic          ge;
    logic [W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_quot[W-1]};
        ge    = (trial >= {1'b0, r_dvsr});
        n_rem = ge ? W'(trial - {1'b0, r_dvsr}) : trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[W-2:0], ge};
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = (r_rem != '0);
    assign o_quot        = r_quot;

endmodule
`default_nettype wire

// File: rtl/core/cdfs_factor_search.sv
`default_nettype none
// walks a upward one per cycle; lane b holds a*b and tests it against the divisor
module cdfs_factor_search #(
    parameter int unsigned MAX_FACTOR = 32,
    parameter int unsigned FW         = $clog2(MAX_FACTOR + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [cdfs_pkg::DIV_W-1:0]   i_div,
    output cdfs_pkg::t_search_stat            o_stat,
    output logic      [FW-1:0]                o_first,
    output logic      [FW-1:0]                o_second
);

    localparam int unsigned PW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

    logic          r_busy;
    logic          r_done;
    logic          r_found;
    logic [FW-1:0] r_a;
    logic [FW-1:0] r_n;
    logic [FW-1:0] r_m;
    logic [PW-1:0] r_prod [MAX_FACTOR];

    logic          hit;
    logic [FW-1:0] match_b;

    always_comb begin
        hit     = 1'b0;
        match_b = '0;
        for (int i = 0; i < MAX_FACTOR; i++) begin
            if (cdfs_pkg::DIV_W'(r_prod[i]) == i_div && FW'(i + 1) >= r_a) begin
                hit     = 1'b1;
                match_b = FW'(i + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (hit || r_a == FW'(MAX_FACTOR))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= FW'(1);
            for (int i = 0; i < MAX_FACTOR; i++) begin
                r_prod[i] <= PW'(i + 1);
            end
        end else if (r_busy) begin
            if (hit) begin
                r_found <= 1'b1;
                r_n     <= r_a;
                r_m     <= match_b;
            end else if (r_a == FW'(MAX_FACTOR)) begin
                // no exact pair, clamp both factors
                r_found <= 1'b0;
                r_n     <= FW'(MAX_FACTOR);
                r_m     <= FW'(MAX_FACTOR);
            end else begin
                r_a <= r_a + FW'(1);
                for (int i = 0; i < MAX_FACTOR; i++) begin
                    r_prod[i] <= r_prod[i] + PW'(i + 1);
                end
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_first      = r_n;
    assign o_second     = r_m;

endmodule
`default_nettype wire

// File: rtl/core/clock_divider_factor_search_unit.sv
// channel   direction  handshake                 beat contents
// in        sink       i_in_valid / o_in_stall   i_target_hz
// out       source     o_out_valid / i_out_stall control word, source, divisor, factors, found
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one request passes from accept through source multiply, the serial divider with its handoffs,
// search start, the factor walk, search result and output load. a zero request skips divide
// and search.
// o_in_stall is low only while the sequencer is idle; a finished result waits in the output
// register and the next request is taken while it is stalled.
// reset is synchronous, active low; configuration returns to crystal 24 MHz, pll 600 MHz.
`default_nettype none
`include "clock_divider_factor_search_unit_macros.svh"
module clock_divider_factor_search_unit #(
    parameter int unsigned MAX_FACTOR          = 32,
    parameter int unsigned FIRST_FACTOR_SHIFT  = 8,
    parameter int unsigned SECOND_FACTOR_SHIFT = 0
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_target_hz,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_control_word,
    output logic             o_source_select,
    output logic [31:0]      o_source_hz,
    output logic [31:0]      o_divisor,
    output logic [5:0]       o_factor_first,
    output logic [5:0]       o_factor_second,
    output logic             o_found,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int unsigned FW = $clog2(MAX_FACTOR + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SRC    = 5'b00010,
        S_DIV    = 5'b00100,
        S_SEARCH = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state        r_state;

    logic [6:0]    r_crystal_mhz;
    logic [10:0]   r_pll_mhz;
    logic          r_prefer_parent;
    logic [31:0]   r_parent_hz;

    logic [31:0]   r_target;
    logic          r_sel;
    logic [31:0]   r_src;
    logic [31:0]   r_div;
    logic [FW-1:0] r_n;
    logic [FW-1:0] r_m;
    logic          r_found;
    logic          r_div_go;
    logic          r_search_go;

    logic          r_out_valid;
    logic [31:0]   r_out_word;
    logic          r_out_sel;
    logic [31:0]   r_out_src;
    logic [31:0]   r_out_div;
    logic [5:0]    r_out_first;
    logic [5:0]    r_out_second;
    logic          r_out_found;

    logic          in_acc;
    logic          out_load;
    logic          low_req;
    logic          use_parent;
    logic [10:0]   src_mhz;
    logic [20:0]   src_scale;
    logic [31:0]   src_prod;
    logic [31:0]   ctrl_word;

    cdfs_pkg::t_div_stat    div_stat;
    logic [31:0]            div_quot;
    cdfs_pkg::t_search_stat srch_stat;
    logic [FW-1:0]          srch_first;
    logic [FW-1:0]          srch_second;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crystal_mhz   <= cdfs_pkg::CRYSTAL_MHZ_RST;
            r_pll_mhz       <= cdfs_pkg::PLL_MHZ_RST;
            r_prefer_parent <= cdfs_pkg::PREFER_PARENT_RST;
            r_parent_hz     <= cdfs_pkg::PARENT_HZ_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cdfs_pkg::CFG_CRYSTAL_MHZ:   r_crystal_mhz   <= i_cfg_data[6:0];
                cdfs_pkg::CFG_PLL_MHZ:       r_pll_mhz       <= i_cfg_data[10:0];
                cdfs_pkg::CFG_PREFER_PARENT: r_prefer_parent <= i_cfg_data[0];
                cdfs_pkg::CFG_PARENT_HZ:     r_parent_hz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // source clock: crystal for low requests, else parent or doubled pll
    always_comb begin
        low_req    = (r_target <= cdfs_pkg::LOW_REQUEST_LIMIT);
        use_parent = r_prefer_parent && (r_parent_hz != '0);
        src_mhz    = low_req ? {4'b0, r_crystal_mhz} : r_pll_mhz;
        src_scale  = low_req ? cdfs_pkg::HZ_PER_MHZ : cdfs_pkg::HZ_PER_MHZ_X2;
        src_prod   = 32'(src_mhz) * 32'(src_scale);
    end

    always_comb begin
        ctrl_word = (32'd1 << cdfs_pkg::CTRL_ENABLE_BIT)
                  | (32'(r_sel) << cdfs_pkg::CTRL_SOURCE_BIT)
                  | ((32'(r_n) - 32'd1) << FIRST_FACTOR_SHIFT)
                  | ((32'(r_m) - 32'd1) << SECOND_FACTOR_SHIFT);
    end

    cdfs_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_src),
        .i_divisor  (r_target),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    cdfs_factor_search #(
        .MAX_FACTOR (MAX_FACTOR),
        .FW         (FW)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_search_go),
        .i_div    (r_div),
        .o_stat   (srch_stat),
        .o_first  (srch_first),
        .o_second (srch_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_go    <= 1'b0;
            r_search_go <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go    <= 1'b0;
            r_search_go <= 1'b0;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_SRC;
                    end
                end
                S_SRC: begin
                    if (r_target == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_div_go <= 1'b1;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_search_go <= 1'b1;
                        r_state     <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (srch_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_target <= i_target_hz;
        end
        if (r_state == S_SRC) begin
            r_sel   <= !low_req;
            r_src   <= (!low_req && use_parent) ? r_parent_hz : src_prod;
            // zero request: no divide, clamped fallback
            r_div   <= '0;
            r_n     <= FW'(MAX_FACTOR);
            r_m     <= FW'(MAX_FACTOR);
            r_found <= 1'b0;
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_div <= div_quot + 32'(div_stat.rem_nz);
        end
        if (r_state == S_SEARCH && srch_stat.done) begin
            r_n     <= srch_first;
            r_m     <= srch_second;
            r_found <= srch_stat.found;
        end
        if (out_load) begin
            r_out_word   <= ctrl_word;
            r_out_sel    <= r_sel;
            r_out_src    <= r_src;
            r_out_div    <= r_div;
            r_out_first  <= 6'(r_n);
            r_out_second <= 6'(r_m);
            r_out_found  <= r_found;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_control_word  = r_out_word;
    assign o_source_select = r_out_sel;
    assign o_source_hz     = r_out_src;
    assign o_divisor       = r_out_div;
    assign o_factor_first  = r_out_first;
    assign o_factor_second = r_out_second;
    assign o_found         = r_out_found;

    `CDFS_ASSERT_NEXT(a_accept_to_src, i_clk, i_rst_n, in_acc, r_state == S_SRC)
    `CDFS_ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, div_stat.done, r_state == S_DIV)
    `CDFS_ASSERT_IMPL(a_pair_exact, i_clk, i_rst_n, srch_stat.done && srch_stat.found, srch_first <= srch_second && 32'(srch_first) * 32'(srch_second) == r_div)
    `CDFS_ASSERT_IMPL(a_fallback_clamp, i_clk, i_rst_n, o_out_valid && !o_found, o_factor_first == 6'(MAX_FACTOR) && o_factor_second == 6'(MAX_FACTOR))

endmodule
`default_nettype wire

// File: dv/clock_divider_factor_search_unit_tb.sv
`default_nettype none
module clock_divider_factor_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_FACTOR          = 32;
    localparam int unsigned FIRST_FACTOR_SHIFT  = 8;
    localparam int unsigned SECOND_FACTOR_SHIFT = 0;
    localparam int unsigned RANDOM_PHASES       = 8;
    localparam int unsigned PHASE_ITEMS         = 100;
    localparam int unsigned CYCLE_LIMIT         = 600000;

    typedef struct {
        logic [31:0] control_word;
        logic        source_select;
        logic [31:0] source_hz;
        logic [31:0] divisor;
        logic [5:0]  factor_first;
        logic [5:0]  factor_second;
        logic        found;
    } t_clock_setting;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_target_hz;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_control_word;
    logic        o_source_select;
    logic [31:0] o_source_hz;
    logic [31:0] o_divisor;
    logic [5:0]  o_factor_first;
    logic [5:0]  o_factor_second;
    logic        o_found;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    // register copies used for prediction
    logic [6:0]  cfg_crystal_mhz;
    logic [10:0] cfg_pll_mhz;
    logic        cfg_prefer_parent;
    logic [31:0] cfg_parent_hz;

    t_clock_setting pending_settings[$];
    t_clock_setting oldest_setting;
    int unsigned    error_count;
    int unsigned    cycle_count;
    int unsigned    out_stall_left;
    logic           out_stall_enable;
    logic           in_gap_enable;

    clock_divider_factor_search_unit #(
        .MAX_FACTOR          (MAX_FACTOR),
        .FIRST_FACTOR_SHIFT  (FIRST_FACTOR_SHIFT),
        .SECOND_FACTOR_SHIFT (SECOND_FACTOR_SHIFT)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_target_hz     (i_target_hz),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_control_word  (o_control_word),
        .o_source_select (o_source_select),
        .o_source_hz     (o_source_hz),
        .o_divisor       (o_divisor),
        .o_factor_first  (o_factor_first),
        .o_factor_second (o_factor_second),
        .o_found         (o_found),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 15);
        else return $urandom_range(30, 80);
    endfunction

    function automatic logic [31:0] source_clock_hz(input logic [31:0] target);
        logic [63:0] wide;
        if (target <= cdfs_pkg::LOW_REQUEST_LIMIT) begin
            wide = cfg_crystal_mhz;
            wide = wide * 64'd1000000;
        end else if (cfg_prefer_parent && cfg_parent_hz != 32'd0) begin
            wide = cfg_parent_hz;
        end else begin
            wide = cfg_pll_mhz;
            wide = wide * 64'd2000000;
        end
        return wide[31:0];
    endfunction

    function automatic t_clock_setting predict_clock_setting(input logic [31:0] target);
        t_clock_setting r;
        logic [63:0]    src;
        logic [63:0]    div;
        int unsigned    a;
        int unsigned    b;
        int unsigned    n;
        int unsigned    m;
        logic           hit;
        logic [31:0]    word;
        src = source_clock_hz(target);
        div = '0;
        n = MAX_FACTOR;
        m = MAX_FACTOR;
        hit = 1'b0;
        if (target != 32'd0) begin
            div = src / target;
            if (src % target != 0) div = div + 1;
            for (a = 1; a <= MAX_FACTOR && !hit; a++) begin
                for (b = a; b <= MAX_FACTOR && !hit; b++) begin
                    if (a * b == div) begin
                        n = a;
                        m = b;
                        hit = 1'b1;
                    end
                end
            end
        end
        r.source_select = (target > cdfs_pkg::LOW_REQUEST_LIMIT);
        word = '0;
        word[cdfs_pkg::CTRL_ENABLE_BIT] = 1'b1;
        word[cdfs_pkg::CTRL_SOURCE_BIT] = r.source_select;
        word = word | ((n - 1) << FIRST_FACTOR_SHIFT) | ((m - 1) << SECOND_FACTOR_SHIFT);
        r.control_word  = word;
        r.source_hz     = src[31:0];
        r.divisor       = div[31:0];
        r.factor_first  = n[5:0];
        r.factor_second = m[5:0];
        r.found         = hit;
        return r;
    endfunction

    // mostly requests aimed at a chosen divisor, so the factor walk gets exercised
    function automatic logic [31:0] pick_target();
        int unsigned r;
        int unsigned a;
        int unsigned d;
        logic [63:0] wide;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'd0;
        if (r < 20) return $urandom;
        if (r < 30) return cdfs_pkg::LOW_REQUEST_LIMIT - 3 + $urandom_range(0, 6);
        if ($urandom_range(0, 9) < 7) begin
            a = $urandom_range(1, MAX_FACTOR);
            d = a * $urandom_range(a, MAX_FACTOR);
        end else begin
            d = $urandom_range(1, 1100);
        end
        wide = source_clock_hz($urandom_range(0, 1) ?
                               cdfs_pkg::LOW_REQUEST_LIMIT + 1 : 32'd1);
        wide = (wide + d - 1) / d;
        if (wide == 0) wide = 1;
        return wide[31:0];
    endfunction

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, label, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_settings.size() == 0) begin
                $display("%0t unexpected result beat: expected none actual %h",
                         $time, o_control_word);
                error_count++;
            end else begin
                oldest_setting = pending_settings.pop_front();
                compare_field("control_word", oldest_setting.control_word, o_control_word);
                compare_field("source_select", 32'(oldest_setting.source_select),
                              32'(o_source_select));
                compare_field("source_hz", oldest_setting.source_hz, o_source_hz);
                compare_field("divisor", oldest_setting.divisor, o_divisor);
                compare_field("factor_first", 32'(oldest_setting.factor_first),
                              32'(o_factor_first));
                compare_field("factor_second", 32'(oldest_setting.factor_second),
                              32'(o_factor_second));
                compare_field("found", 32'(oldest_setting.found), 32'(o_found));
            end
        end
        if (out_stall_left != 0) begin
            i_out_stall <= 1'b1;
            out_stall_left--;
        end else if (out_stall_enable && $urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            out_stall_left = pick_gap();
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, pending_settings.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // valid stays high across back-to-back beats, lowered only ahead of a gap
    task automatic send_request(input logic [31:0] target);
        int unsigned gap;
        gap = in_gap_enable ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_target_hz <= target;
        do @(posedge i_clk); while (o_in_stall);
        pending_settings.push_back(predict_clock_setting(target));
    endtask

    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_settings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        quiesce();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            cdfs_pkg::CFG_CRYSTAL_MHZ:   cfg_crystal_mhz   = data[6:0];
            cdfs_pkg::CFG_PLL_MHZ:       cfg_pll_mhz       = data[10:0];
            cdfs_pkg::CFG_PREFER_PARENT: cfg_prefer_parent = data[0];
            cdfs_pkg::CFG_PARENT_HZ:     cfg_parent_hz     = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_crystal_requests();
        send_request(32'd0);
        send_request(32'd1);
        send_request(32'd23437);     // divisor 1025, no pair
        send_request(32'd23438);     // divisor 1024, largest pair
        send_request(32'd648649);    // prime divisor above the factor range
        send_request(32'd1000000);
        send_request(cdfs_pkg::LOW_REQUEST_LIMIT);
    endtask

    task automatic test_pll_requests();
        send_request(cdfs_pkg::LOW_REQUEST_LIMIT + 1);
        send_request(32'd50000000);
        send_request(32'd1199999999);
        send_request(32'd1200000000);
        send_request(32'hFFFF_FFFF);
    endtask

    task automatic test_parent_clock();
        // preferred but zero parent falls back to the pll
        write_register(cdfs_pkg::CFG_PREFER_PARENT, 32'd1);
        send_request(32'd100000000);
        write_register(cdfs_pkg::CFG_PARENT_HZ, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF);
        send_request(cdfs_pkg::LOW_REQUEST_LIMIT + 1);
        write_register(cdfs_pkg::CFG_PREFER_PARENT, 32'd0);
        send_request(32'd100000000);
    endtask

    task automatic test_register_extremes();
        write_register(cdfs_pkg::CFG_CRYSTAL_MHZ, 32'd0);
        send_request(32'd1000);
        write_register(cdfs_pkg::CFG_CRYSTAL_MHZ, 32'd127);
        send_request(cdfs_pkg::LOW_REQUEST_LIMIT);
        write_register(cdfs_pkg::CFG_CRYSTAL_MHZ, 32'd64);
        send_request(32'd2000000);
        write_register(cdfs_pkg::CFG_PLL_MHZ, 32'd0);
        send_request(32'd5000000);
        write_register(cdfs_pkg::CFG_PLL_MHZ, 32'd2047);
        send_request(cdfs_pkg::LOW_REQUEST_LIMIT + 1);
        write_register(cdfs_pkg::CFG_PLL_MHZ, 32'd1);
        send_request(cdfs_pkg::LOW_REQUEST_LIMIT + 1);
    endtask

    task automatic test_random_requests();
        int unsigned phase;
        int unsigned k;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            // first phase runs without idling on either side
            out_stall_enable = (phase != 0);
            in_gap_enable    = (phase != 0);
            if (phase == 1) begin
                write_register(cdfs_pkg::CFG_CRYSTAL_MHZ, 32'd64);
                write_register(cdfs_pkg::CFG_PLL_MHZ, 32'd1200);
                write_register(cdfs_pkg::CFG_PREFER_PARENT, 32'd1);
                write_register(cdfs_pkg::CFG_PARENT_HZ, $urandom);
            end else if (phase == 2) begin
                write_register(cdfs_pkg::CFG_CRYSTAL_MHZ, 32'd1);
                write_register(cdfs_pkg::CFG_PLL_MHZ, 32'd1);
                write_register(cdfs_pkg::CFG_PREFER_PARENT, 32'd0);
                write_register(cdfs_pkg::CFG_PARENT_HZ, 32'd0);
            end else if (phase > 2) begin
                write_register(cdfs_pkg::CFG_CRYSTAL_MHZ, $urandom_range(0, 3) == 0 ?
                               $urandom_range(0, 127) : $urandom_range(1, 64));
                write_register(cdfs_pkg::CFG_PLL_MHZ, $urandom_range(0, 3) == 0 ?
                               $urandom_range(0, 2047) : $urandom_range(1, 1200));
                write_register(cdfs_pkg::CFG_PREFER_PARENT, $urandom);
                write_register(cdfs_pkg::CFG_PARENT_HZ,
                               $urandom_range(0, 3) == 0 ? 32'd0 : $urandom);
            end
            for (k = 0; k < PHASE_ITEMS; k++) send_request(pick_target());
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_target_hz <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        cfg_crystal_mhz   = cdfs_pkg::CRYSTAL_MHZ_RST;
        cfg_pll_mhz       = cdfs_pkg::PLL_MHZ_RST;
        cfg_prefer_parent = cdfs_pkg::PREFER_PARENT_RST;
        cfg_parent_hz     = cdfs_pkg::PARENT_HZ_RST;
        error_count      = 0;
        cycle_count      = 0;
        out_stall_left   = 0;
        out_stall_enable = 1'b1;
        in_gap_enable    = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_crystal_requests();
        test_pll_requests();
        test_parent_clock();
        test_register_extremes();
        test_random_requests();

        quiesce();
        repeat (MAX_FACTOR + 40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/cdfs_pkg.sv
rtl/core/cdfs_divider.sv
rtl/core/cdfs_factor_search.sv
rtl/core/clock_divider_factor_search_unit.sv
dv/clock_divider_factor_search_unit_tb.sv
